[rtl/acpu_pkg.sv]
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared types, constants and codes of the accumulator CPU.
// ----------------------------------------------------------------------------
package acpu_pkg;

	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 11;
	localparam int MEM_WORDS = 2048;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int UC_W      = 16;
	localparam int RAND_W    = 7;

	localparam logic [ADDR_W-1:0] SYS_BASE    = ADDR_W'(1000);
	localparam logic [ADDR_W-1:0] TIMER_VEC   = ADDR_W'(1000);
	localparam logic [ADDR_W-1:0] SYSCALL_VEC = ADDR_W'(1500);
	localparam logic [ADDR_W-1:0] SAVE_TOP    = ADDR_W'(1999);
	localparam logic [ADDR_W-1:0] SAVE_NEXT   = ADDR_W'(1998);
	localparam logic [UC_W-1:0]   TINT_RESET  = UC_W'(100);

	// Opcodes
	localparam logic [DATA_W-1:0] OP_LDV   = 32'd1;
	localparam logic [DATA_W-1:0] OP_LDA   = 32'd2;
	localparam logic [DATA_W-1:0] OP_LDI   = 32'd3;
	localparam logic [DATA_W-1:0] OP_LDX   = 32'd4;
	localparam logic [DATA_W-1:0] OP_LDY   = 32'd5;
	localparam logic [DATA_W-1:0] OP_LDSPX = 32'd6;
	localparam logic [DATA_W-1:0] OP_ST    = 32'd7;
	localparam logic [DATA_W-1:0] OP_RAND  = 32'd8;
	localparam logic [DATA_W-1:0] OP_PUT   = 32'd9;
	localparam logic [DATA_W-1:0] OP_ADDX  = 32'd10;
	localparam logic [DATA_W-1:0] OP_ADDY  = 32'd11;
	localparam logic [DATA_W-1:0] OP_SUBX  = 32'd12;
	localparam logic [DATA_W-1:0] OP_SUBY  = 32'd13;
	localparam logic [DATA_W-1:0] OP_CPTX  = 32'd14;
	localparam logic [DATA_W-1:0] OP_CPFX  = 32'd15;
	localparam logic [DATA_W-1:0] OP_CPTY  = 32'd16;
	localparam logic [DATA_W-1:0] OP_CPFY  = 32'd17;
	localparam logic [DATA_W-1:0] OP_CPTSP = 32'd18;
	localparam logic [DATA_W-1:0] OP_CPFSP = 32'd19;
	localparam logic [DATA_W-1:0] OP_JMP   = 32'd20;
	localparam logic [DATA_W-1:0] OP_JEQ   = 32'd21;
	localparam logic [DATA_W-1:0] OP_JNE   = 32'd22;
	localparam logic [DATA_W-1:0] OP_CALL  = 32'd23;
	localparam logic [DATA_W-1:0] OP_RET   = 32'd24;
	localparam logic [DATA_W-1:0] OP_INCX  = 32'd25;
	localparam logic [DATA_W-1:0] OP_DECX  = 32'd26;
	localparam logic [DATA_W-1:0] OP_PUSH  = 32'd27;
	localparam logic [DATA_W-1:0] OP_POP   = 32'd28;
	localparam logic [DATA_W-1:0] OP_INT   = 32'd29;
	localparam logic [DATA_W-1:0] OP_IRET  = 32'd30;
	localparam logic [DATA_W-1:0] OP_END   = 32'd50;

	// Output kinds and stop codes
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_INT  = 2'd1;
	localparam logic [1:0] KIND_CHAR = 2'd2;
	localparam logic [1:0] STOP_RUN  = 2'd0;
	localparam logic [1:0] STOP_END  = 2'd1;
	localparam logic [1:0] STOP_VIOL = 2'd2;

	// Read address sources
	localparam logic [2:0] RA_PC  = 3'd0;
	localparam logic [2:0] RA_MD  = 3'd1;
	localparam logic [2:0] RA_MDX = 3'd2;
	localparam logic [2:0] RA_MDY = 3'd3;
	localparam logic [2:0] RA_SPX = 3'd4;
	localparam logic [2:0] RA_SP  = 3'd5;

	// Write address sources
	localparam logic [2:0] WA_LOAD  = 3'd0;
	localparam logic [2:0] WA_MD    = 3'd1;
	localparam logic [2:0] WA_SPM   = 3'd2;
	localparam logic [2:0] WA_SAVE  = 3'd3;
	localparam logic [2:0] WA_SAVE1 = 3'd4;

	// Write data sources
	localparam logic [1:0] WD_LOAD = 2'd0;
	localparam logic [1:0] WD_AC   = 2'd1;
	localparam logic [1:0] WD_PC   = 2'd2;
	localparam logic [1:0] WD_SP   = 2'd3;

	// Register operations
	localparam logic [3:0] RO_NONE  = 4'd0;
	localparam logic [3:0] RO_ACMD  = 4'd1;
	localparam logic [3:0] RO_RAND  = 4'd2;
	localparam logic [3:0] RO_ADDX  = 4'd3;
	localparam logic [3:0] RO_ADDY  = 4'd4;
	localparam logic [3:0] RO_SUBX  = 4'd5;
	localparam logic [3:0] RO_SUBY  = 4'd6;
	localparam logic [3:0] RO_XAC   = 4'd7;
	localparam logic [3:0] RO_ACX   = 4'd8;
	localparam logic [3:0] RO_YAC   = 4'd9;
	localparam logic [3:0] RO_ACY   = 4'd10;
	localparam logic [3:0] RO_SPAC  = 4'd11;
	localparam logic [3:0] RO_ACSP  = 4'd12;
	localparam logic [3:0] RO_INCX  = 4'd13;
	localparam logic [3:0] RO_DECX  = 4'd14;

	typedef struct packed {
		logic       latch_in;
		logic       rd;
		logic [2:0] rsel;
		logic       wr;
		logic [2:0] wasel;
		logic [1:0] wdsel;
		logic       pc_inc;
		logic       pc_ld_md;
		logic       sp_inc;
		logic       sp_dec;
		logic       sp_ld_md;
		logic [3:0] rop;
		logic       kern_clr;
		logic       int_enter;
		logic       vec_sys;
		logic       set_kind;
		logic       set_halt;
		logic       count;
		logic       out_ld;
	} acpu_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] md;
		logic              viol;
		logic              ac_zero;
		logic              timer_due;
		logic              halted;
		logic              out_busy;
	} acpu_stat_t;

	// Folds a wrapped 11-bit address into the memory depth.
	function automatic logic [MEM_AW-1:0] slot(input logic [ADDR_W-1:0] a);
		logic [ADDR_W:0] t;
		t = {1'b0, a};
		if (t >= (ADDR_W+1)'(MEM_WORDS))
			t = t - (ADDR_W+1)'(MEM_WORDS);
		return t[MEM_AW-1:0];
	endfunction

endpackage

[rtl/acpu_ram.sv]
// ----------------------------------------------------------------------------
// acpu_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module acpu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata <= mem_q[addr];
		end
	end

endmodule

[rtl/acpu_dp.sv]
// ----------------------------------------------------------------------------
// acpu_dp
// Datapath: architectural registers, memory, address muxes and result register.
// ----------------------------------------------------------------------------
module acpu_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  acpu_pkg::acpu_cmd_t cmd,
	output acpu_pkg::acpu_stat_t st,
	input  logic [55:0]        s_tdata,
	input  logic               cfg_wen,
	input  logic [15:0]        cfg_wdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata,
	output logic [1:0]         m_tuser
);
	import acpu_pkg::*;

	logic [ADDR_W-1:0] pc_q, sp_q;
	logic [DATA_W-1:0] ac_q, x_q, y_q;
	logic              kern_q;
	logic [UC_W-1:0]   uc_q, tint_q;
	logic [1:0]        stop_q, kind_q;
	logic [RAND_W-1:0] rand_q;
	logic [DATA_W-1:0] md;
	logic [ADDR_W-1:0] ra, wa;
	logic [DATA_W-1:0] wd;
	logic [MEM_AW-1:0] maddr;
	logic              viol;
	logic [DATA_W-1:0] val_q;
	logic [1:0]        okind_q, ostat_q;
	logic [ADDR_W-1:0] opc_q;
	logic              ovalid_q;

	wire [ADDR_W-1:0] in_addr = s_tdata[10:0];
	wire [DATA_W-1:0] in_data = s_tdata[42:11];
	wire [RAND_W-1:0] in_rand = s_tdata[49:43];

	always_comb begin
		case (cmd.rsel)
			RA_PC:   ra = pc_q;
			RA_MD:   ra = md[ADDR_W-1:0];
			RA_MDX:  ra = md[ADDR_W-1:0] + x_q[ADDR_W-1:0];
			RA_MDY:  ra = md[ADDR_W-1:0] + y_q[ADDR_W-1:0];
			RA_SPX:  ra = sp_q + x_q[ADDR_W-1:0];
			RA_SP:   ra = sp_q;
			default: ra = pc_q;
		endcase
		case (cmd.wasel)
			WA_LOAD:  wa = in_addr;
			WA_MD:    wa = md[ADDR_W-1:0];
			WA_SPM:   wa = sp_q - 1'b1;
			WA_SAVE:  wa = SAVE_TOP;
			WA_SAVE1: wa = SAVE_NEXT;
			default:  wa = in_addr;
		endcase
		case (cmd.wdsel)
			WD_LOAD: wd = in_data;
			WD_AC:   wd = ac_q;
			WD_PC:   wd = {{(DATA_W-ADDR_W){1'b0}}, pc_q};
			WD_SP:   wd = {{(DATA_W-ADDR_W){1'b0}}, sp_q};
			default: wd = in_data;
		endcase
	end

	assign viol  = cmd.rd && !kern_q && (ra >= SYS_BASE);
	assign maddr = cmd.wr ? slot(wa) : slot(ra);

	acpu_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.addr  (maddr),
		.wdata (wd),
		.rdata (md)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			sp_q   <= SYS_BASE;
			ac_q   <= '0;
			x_q    <= '0;
			y_q    <= '0;
			kern_q <= 1'b0;
			uc_q   <= '0;
			tint_q <= TINT_RESET;
			stop_q <= STOP_RUN;
			kind_q <= KIND_NONE;
		end else begin
			if (cfg_wen)
				tint_q <= cfg_wdata;
			if (cmd.latch_in)
				kind_q <= KIND_NONE;
			if (cmd.int_enter)
				pc_q <= cmd.vec_sys ? SYSCALL_VEC : TIMER_VEC;
			else if (cmd.pc_ld_md)
				pc_q <= md[ADDR_W-1:0];
			else if (cmd.pc_inc)
				pc_q <= pc_q + 1'b1;
			if (cmd.int_enter)
				sp_q <= SAVE_NEXT;
			else if (cmd.sp_ld_md)
				sp_q <= md[ADDR_W-1:0];
			else if (cmd.sp_inc)
				sp_q <= sp_q + 1'b1;
			else if (cmd.sp_dec)
				sp_q <= sp_q - 1'b1;
			else if (cmd.rop == RO_SPAC)
				sp_q <= ac_q[ADDR_W-1:0];
			case (cmd.rop)
				RO_ACMD: ac_q <= md;
				RO_RAND: ac_q <= {{(DATA_W-RAND_W){1'b0}}, rand_q};
				RO_ADDX: ac_q <= ac_q + x_q;
				RO_ADDY: ac_q <= ac_q + y_q;
				RO_SUBX: ac_q <= ac_q - x_q;
				RO_SUBY: ac_q <= ac_q - y_q;
				RO_XAC:  x_q  <= ac_q;
				RO_ACX:  ac_q <= x_q;
				RO_YAC:  y_q  <= ac_q;
				RO_ACY:  ac_q <= y_q;
				RO_ACSP: ac_q <= {{(DATA_W-ADDR_W){1'b0}}, sp_q};
				RO_INCX: x_q  <= x_q + 1'b1;
				RO_DECX: x_q  <= x_q - 1'b1;
				default: ;
			endcase
			if (cmd.int_enter)
				kern_q <= 1'b1;
			else if (cmd.kern_clr)
				kern_q <= 1'b0;
			if (cmd.int_enter && !cmd.vec_sys)
				uc_q <= '0;
			else if (cmd.count && stop_q == STOP_RUN && !kern_q)
				uc_q <= uc_q + 1'b1;
			if (viol)
				stop_q <= STOP_VIOL;
			else if (cmd.set_halt)
				stop_q <= STOP_END;
			if (cmd.set_kind) begin
				if (md == DATA_W'(KIND_INT))
					kind_q <= KIND_INT;
				else if (md == DATA_W'(KIND_CHAR))
					kind_q <= KIND_CHAR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in)
			rand_q <= in_rand;
	end

	// Result register: the next item may run while this one waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.out_ld)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			okind_q <= (stop_q == STOP_RUN) ? kind_q : KIND_NONE;
			val_q   <= (stop_q == STOP_RUN && kind_q != KIND_NONE) ? ac_q : '0;
			ostat_q <= stop_q;
			opc_q   <= pc_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tuser  = okind_q;
	assign m_tdata  = {3'b000, opc_q, ostat_q, val_q};

	assign st.md        = md;
	assign st.viol      = viol;
	assign st.ac_zero   = (ac_q == '0);
	assign st.timer_due = (uc_q >= tint_q);
	assign st.halted    = (stop_q != STOP_RUN);
	assign st.out_busy  = ovalid_q && !m_tready;

endmodule

[rtl/acpu_ctrl.sv]
// ----------------------------------------------------------------------------
// acpu_ctrl
// Instruction sequencer: steps each item through fetch, operand and memory accesses.
// ----------------------------------------------------------------------------
module acpu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 in_op,
	input  acpu_pkg::acpu_stat_t st,
	output acpu_pkg::acpu_cmd_t  cmd
);
	import acpu_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_OP1  = 4'd2;
	localparam logic [3:0] S_IND  = 4'd3;
	localparam logic [3:0] S_LDAC = 4'd4;
	localparam logic [3:0] S_JMP  = 4'd5;
	localparam logic [3:0] S_RTI1 = 4'd6;
	localparam logic [3:0] S_RTI2 = 4'd7;
	localparam logic [3:0] S_INT1 = 4'd8;
	localparam logic [3:0] S_INT2 = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;
	localparam logic [3:0] S_RESP = 4'd11;

	logic [3:0]        state_q, nxt;
	logic [DATA_W-1:0] ir_q;
	logic              sys_q, sys_d;

	always_comb begin
		cmd      = '0;
		nxt      = state_q;
		sys_d    = sys_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch_in = 1'b1;
					if (!in_op) begin
						cmd.wr    = 1'b1;
						cmd.wasel = WA_LOAD;
						cmd.wdsel = WD_LOAD;
						nxt       = S_RESP;
					end else if (st.halted) begin
						nxt = S_RESP;
					end else if (st.timer_due) begin
						sys_d = 1'b0;
						nxt   = S_INT1;
					end else begin
						cmd.rd     = 1'b1;
						cmd.rsel   = RA_PC;
						cmd.pc_inc = 1'b1;
						nxt        = st.viol ? S_FIN : S_DEC;
					end
				end
			end
			S_DEC: begin
				nxt = S_FIN;
				case (st.md)
					OP_LDV, OP_LDA, OP_LDI, OP_LDX, OP_LDY, OP_ST, OP_PUT,
					OP_JMP, OP_CALL: begin
						cmd.rd     = 1'b1;
						cmd.rsel   = RA_PC;
						cmd.pc_inc = 1'b1;
						nxt        = st.viol ? S_FIN : S_OP1;
					end
					OP_JEQ, OP_JNE: begin
						cmd.pc_inc = 1'b1;
						if (st.ac_zero == (st.md == OP_JEQ)) begin
							cmd.rd   = 1'b1;
							cmd.rsel = RA_PC;
							nxt      = st.viol ? S_FIN : S_OP1;
						end
					end
					OP_LDSPX: begin
						cmd.rd   = 1'b1;
						cmd.rsel = RA_SPX;
						nxt      = st.viol ? S_FIN : S_LDAC;
					end
					OP_RAND:  cmd.rop = RO_RAND;
					OP_ADDX:  cmd.rop = RO_ADDX;
					OP_ADDY:  cmd.rop = RO_ADDY;
					OP_SUBX:  cmd.rop = RO_SUBX;
					OP_SUBY:  cmd.rop = RO_SUBY;
					OP_CPTX:  cmd.rop = RO_XAC;
					OP_CPFX:  cmd.rop = RO_ACX;
					OP_CPTY:  cmd.rop = RO_YAC;
					OP_CPFY:  cmd.rop = RO_ACY;
					OP_CPTSP: cmd.rop = RO_SPAC;
					OP_CPFSP: cmd.rop = RO_ACSP;
					OP_INCX:  cmd.rop = RO_INCX;
					OP_DECX:  cmd.rop = RO_DECX;
					OP_RET, OP_POP, OP_IRET: begin
						cmd.rd     = 1'b1;
						cmd.rsel   = RA_SP;
						cmd.sp_inc = 1'b1;
						if (st.viol)
							nxt = S_FIN;
						else if (st.md == OP_RET)
							nxt = S_JMP;
						else if (st.md == OP_POP)
							nxt = S_LDAC;
						else
							nxt = S_RTI1;
					end
					OP_PUSH: begin
						cmd.wr     = 1'b1;
						cmd.wasel  = WA_SPM;
						cmd.wdsel  = WD_AC;
						cmd.sp_dec = 1'b1;
					end
					OP_INT: begin
						sys_d = 1'b1;
						nxt   = S_INT1;
					end
					OP_END:  cmd.set_halt = 1'b1;
					default: ;
				endcase
			end
			S_OP1: begin
				nxt = S_FIN;
				case (ir_q)
					OP_LDV: cmd.rop = RO_ACMD;
					OP_LDA, OP_LDI, OP_LDX, OP_LDY: begin
						cmd.rd = 1'b1;
						if (ir_q == OP_LDX)
							cmd.rsel = RA_MDX;
						else if (ir_q == OP_LDY)
							cmd.rsel = RA_MDY;
						else
							cmd.rsel = RA_MD;
						if (st.viol)
							nxt = S_FIN;
						else
							nxt = (ir_q == OP_LDI) ? S_IND : S_LDAC;
					end
					OP_ST: begin
						cmd.wr    = 1'b1;
						cmd.wasel = WA_MD;
						cmd.wdsel = WD_AC;
					end
					OP_PUT: cmd.set_kind = 1'b1;
					OP_CALL: begin
						cmd.wr       = 1'b1;
						cmd.wasel    = WA_SPM;
						cmd.wdsel    = WD_PC;
						cmd.sp_dec   = 1'b1;
						cmd.pc_ld_md = 1'b1;
					end
					default: cmd.pc_ld_md = 1'b1;
				endcase
			end
			S_IND: begin
				cmd.rd   = 1'b1;
				cmd.rsel = RA_MD;
				nxt      = st.viol ? S_FIN : S_LDAC;
			end
			S_LDAC: begin
				cmd.rop = RO_ACMD;
				nxt     = S_FIN;
			end
			S_JMP: begin
				cmd.pc_ld_md = 1'b1;
				nxt          = S_FIN;
			end
			S_RTI1: begin
				cmd.pc_ld_md = 1'b1;
				cmd.rd       = 1'b1;
				cmd.rsel     = RA_SP;
				cmd.sp_inc   = 1'b1;
				nxt          = st.viol ? S_FIN : S_RTI2;
			end
			S_RTI2: begin
				cmd.sp_ld_md = 1'b1;
				cmd.kern_clr = 1'b1;
				nxt          = S_FIN;
			end
			S_INT1: begin
				cmd.wr    = 1'b1;
				cmd.wasel = WA_SAVE;
				cmd.wdsel = WD_SP;
				nxt       = S_INT2;
			end
			S_INT2: begin
				cmd.wr        = 1'b1;
				cmd.wasel     = WA_SAVE1;
				cmd.wdsel     = WD_PC;
				cmd.int_enter = 1'b1;
				cmd.vec_sys   = sys_q;
				nxt           = sys_q ? S_FIN : S_RESP;
			end
			S_FIN: begin
				cmd.count = 1'b1;
				nxt       = S_RESP;
			end
			S_RESP: begin
				if (!st.out_busy) begin
					cmd.out_ld = 1'b1;
					nxt        = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sys_q   <= 1'b0;
		end else begin
			state_q <= nxt;
			sys_q   <= sys_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DEC)
			ir_q <= st.md;
	end

endmodule

[rtl/accumulator_cpu_with_timer_interrupt.sv]
// ----------------------------------------------------------------------------
// accumulator_cpu_with_timer_interrupt
// Accumulator CPU with timer interrupt and internal 2048-word memory.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_*       | in        | tuser: op; tdata: load_address, load_data, rand_value
//  m_*       | out       | tuser: out_kind; tdata: out_value, status, pc_now
//  cfg_*     | in        | timer_interval write
//
// A load item writes memory and then reports. A step reports at once when
// halted, passes through S_FIN when the fetch itself is a violation, and
// otherwise runs a chain of single-port memory accesses (fetch, operand,
// indirection, stack pops). Reset clears the control and architectural
// registers but not memory, rand_q, ir_q or the result data. The result
// waits in an output register, so a stall on m_* holds only the next result, not the next input transfer.
// ----------------------------------------------------------------------------
module accumulator_cpu_with_timer_interrupt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // load_address, load_data, rand_value
	input  logic [0:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_value, status, pc_now
	output logic [1:0]  m_tuser,   // out_kind
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata
);
	import acpu_pkg::*;

	acpu_cmd_t  cmd;
	acpu_stat_t st;

	acpu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_op    (s_tuser[0]),
		.st       (st),
		.cmd      (cmd)
	);

	acpu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

[rtl/acpu_chk.sv]
// ----------------------------------------------------------------------------
// acpu_chk
// Port-level checks of the accumulator CPU, bound to the top level.
// ----------------------------------------------------------------------------
module acpu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A held result must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// One item in flight: no input transfer right after another.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// Output is only reported while running.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != 2'd0 |-> m_tdata[33:32] == 2'd0)
		else $error("output reported after halt");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3 && m_tdata[33:32] != 2'd3)
		else $error("invalid kind or status code");

endmodule

bind accumulator_cpu_with_timer_interrupt acpu_chk u_acpu_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
